// ----- rtl/bouncing_palette_generator_top_defines.svh -----
// Assertion macros shared by the palette generator RTL files.
`ifndef BOUNCING_PALETTE_GENERATOR_TOP_DEFINES_SVH
`define BOUNCING_PALETTE_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BPG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("palette generator check failed");

// Next-cycle implication.
`define BPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("palette generator check failed");

`else

`define BPG_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BPG_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/bpg_pkg.sv -----
// Types, register indexes and the fixed color map of the palette generator.
`timescale 1ns / 1ps

package bpg_pkg;

  typedef logic signed [9:0] lvl_t;
  typedef logic signed [8:0] stp_t;
  typedef logic [30:0]       pat_t;

  typedef struct packed {
    logic [5:0] gradient;
    pat_t       start_pattern;
    pat_t       bounce_pattern;
  } cfg_t;

  typedef struct packed {
    logic [7:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef logic [255:0][23:0] fmap_t;

  localparam logic [2:0] REG_GRADIENT       = 3'd0;
  localparam logic [2:0] REG_START_PATTERN  = 3'd1;
  localparam logic [2:0] REG_BOUNCE_PATTERN = 3'd2;
  localparam logic [2:0] REG_ALPHA_VALUE    = 3'd3;

  // scale * mag for a two-bit magnitude, as shift and add
  function automatic logic [7:0] mag_scale(input logic [5:0] scale, input logic [1:0] mag);
    logic [7:0] dbl;
    logic [7:0] one;
    dbl = {1'b0, scale, 1'b0} & {8{mag[1]}};
    one = {2'b00, scale} & {8{mag[0]}};
    return dbl + one;
  endfunction

  function automatic int round_ratio(input int num);
    return (2 * num + 255) / 510;
  endfunction

  // Four-segment standard map, evaluated at elaboration only
  function automatic fmap_t build_fixed_map();
    fmap_t m;
    int r;
    int g;
    int b;
    for (int i = 0; i < 256; i++) begin
      if (i < 85) begin
        b = round_ratio(64 * (255 - 3 * i));
        r = b;
        g = round_ratio(64 * 255 + 384 * i);
      end else if (i < 170) begin
        b = 0;
        g = round_ratio(129 * 255 + 189 * i);
        r = 3 * i - 255;
      end else if (i < 255) begin
        b = 0;
        g = 765 - 3 * i;
        r = 255;
      end else begin
        b = 0;
        g = 0;
        r = 255;
      end
      m[i] = {8'(r), 8'(g), 8'(b)};
    end
    return m;
  endfunction

  localparam fmap_t FIXED_MAP = build_fixed_map();

endpackage

// ----- rtl/bouncing_palette_generator_top.sv -----
// Top level of the bouncing palette generator: config, request and result registers.
`timescale 1ns / 1ps
`include "bouncing_palette_generator_top_defines.svh"

// Path: an accepted request waits in the request register and moves to the result
//   register when that register is free or drains; out_ready low holds it back.
// Throughput: one palette entry per cycle while out_ready is high; the core's state
//   update loop closes level, step and pattern state before the next request.
// Reset: synchronous, active low; clears configuration, palette state and valid
//   flags, and the next request starts a new palette at entry zero.
module bouncing_palette_generator_top
  import bpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_entry_index,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        out_last
);

  logic [5:0] gradient_r;
  pat_t       start_pattern_r;
  pat_t       bounce_pattern_r;
  logic [7:0] alpha_value_r;
  cfg_t       cfg;

  logic       s1_valid_r;
  logic       s1_restart_r;
  logic       s1_adv;
  logic       in_fire;

  logic       out_valid_r;
  pix_t       out_pix_r;
  logic [7:0] out_alpha_r;
  pix_t       pix;

  // Configuration writes; indexes past the register list drop silently
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gradient_r       <= '0;
      start_pattern_r  <= '0;
      bounce_pattern_r <= '0;
      alpha_value_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRADIENT:       gradient_r       <= cfg_data[5:0];
        REG_START_PATTERN:  start_pattern_r  <= cfg_data;
        REG_BOUNCE_PATTERN: bounce_pattern_r <= cfg_data;
        REG_ALPHA_VALUE:    alpha_value_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg.gradient       = gradient_r;
  assign cfg.start_pattern  = start_pattern_r;
  assign cfg.bounce_pattern = bounce_pattern_r;

  // Advance the held request whenever the result register is free or drains
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Hold the request payload until it moves on
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_restart_r <= in_restart;
    end
  end

  // Core computes the entry and updates palette state as the request advances
  bpg_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (s1_adv),
    .restart_i (s1_restart_r),
    .cfg_i     (cfg),
    .pix_o     (pix)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Capture the result; alpha is sampled live as the entry is produced
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pix_r   <= pix;
      out_alpha_r <= alpha_value_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry_index = out_pix_r.idx;
  assign out_red         = out_pix_r.red;
  assign out_green       = out_pix_r.green;
  assign out_blue        = out_pix_r.blue;
  assign out_alpha       = out_alpha_r;
  assign out_last        = out_pix_r.idx == 8'd255;

  `BPG_ASSERT_NEXT(a_req_held, clk, rst_n, s1_valid_r && !s1_adv,
    s1_valid_r && $stable(s1_restart_r))
  `BPG_ASSERT_NEXT(a_adv_fills, clk, rst_n, s1_adv,
    out_valid_r && out_entry_index == $past(pix.idx))
  `BPG_ASSERT_NEXT(a_drain_empties, clk, rst_n, out_valid_r && out_ready && !s1_adv,
    !out_valid_r)

endmodule

// ----- rtl/bpg_refill.sv -----
// Increment refill: pick the first nonzero six-bit group of the start bits.
`timescale 1ns / 1ps

module bpg_refill
  import bpg_pkg::*;
(
  input  logic            steps_zero_i,
  input  pat_t            bits_i,
  input  logic [5:0]      scale_i,
  output logic            load_o,
  output logic [2:0][7:0] mag_o,
  output pat_t            bits_o
);

  logic [35:0] ext;
  logic [5:0]  grp;
  logic [5:0]  sel;
  logic        hit;
  pat_t        rest;

  always_comb begin
    ext  = {5'b0, bits_i};
    hit  = 1'b0;
    sel  = '0;
    rest = '0;
    // lowest nonzero group wins; the bits above it are what remain
    for (int g = 0; g < 6; g++) begin
      grp = ext[6*g +: 6];
      if (!hit && grp != 6'd0) begin
        hit  = 1'b1;
        sel  = grp;
        rest = 31'(ext >> (6 * (g + 1)));
      end
    end
    load_o = steps_zero_i && (bits_i != '0);
    if (load_o) begin
      mag_o[0] = mag_scale(scale_i, sel[1:0]);
      mag_o[1] = mag_scale(scale_i, sel[3:2]);
      mag_o[2] = mag_scale(scale_i, sel[5:4]);
      bits_o   = rest;
    end else begin
      mag_o  = '0;
      bits_o = bits_i;
    end
  end

endmodule

// ----- rtl/bpg_core.sv -----
// Palette state, bounce and entry logic: one request per cycle when step_i is high.
`timescale 1ns / 1ps
`include "bouncing_palette_generator_top_defines.svh"

module bpg_core
  import bpg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic step_i,
  input  logic restart_i,
  input  cfg_t cfg_i,
  output pix_t pix_o
);

  lvl_t       lvl_r [3];
  lvl_t       lvl_nxt [3];
  lvl_t       lvl_b [3];
  lvl_t       lvl_s [3];
  stp_t       stp_r [3];
  stp_t       stp_nxt [3];
  stp_t       stp_b [3];
  stp_t       stp_s [3];
  stp_t       base_stp;
  pat_t       sbl_r;
  pat_t       sbl_nxt;
  pat_t       bbl_r;
  pat_t       bbl_nxt;
  pat_t       bbl_b;
  logic [7:0] next_idx_r;
  logic [7:0] idx;
  logic       grad_on;
  logic       start;
  logic [1:0] ofs;
  logic [1:0] pair;
  logic [7:0] bmag;
  logic       hi;
  logic       lo;
  logic       rf_zero;
  pat_t       rf_bits_in;
  logic       rf_load;
  logic [2:0][7:0] rf_mag;
  pat_t       rf_bits;
  logic [23:0] fixed_rgb;

  assign idx     = restart_i ? 8'd0 : next_idx_r;
  assign grad_on = cfg_i.gradient != 6'd0;
  assign start   = grad_on && (idx == 8'd0);

  // Bounce: clamp each channel in turn, each bounce consumes two pattern bits
  always_comb begin
    ofs = 2'd0;
    for (int c = 0; c < 3; c++) begin
      hi   = !lvl_r[c][9] && lvl_r[c][8];
      lo   = lvl_r[c][9];
      pair = 2'(bbl_r >> {ofs, 1'b0});
      bmag = mag_scale(cfg_i.gradient, pair);
      lvl_b[c] = lvl_r[c];
      stp_b[c] = stp_r[c];
      if (hi) begin
        lvl_b[c] = 10'sd255;
        stp_b[c] = -$signed({1'b0, bmag});
      end else if (lo) begin
        lvl_b[c] = 10'sd0;
        stp_b[c] = $signed({1'b0, bmag});
      end
      ofs = ofs + {1'b0, hi | lo};
    end
    bbl_b = bbl_r >> {ofs, 1'b0};
  end

  // A new palette refills from zero steps and the full start pattern
  assign rf_zero    = start || (stp_b[0] == '0 && stp_b[1] == '0 && stp_b[2] == '0);
  assign rf_bits_in = start ? cfg_i.start_pattern : sbl_r;

  bpg_refill u_refill (
    .steps_zero_i (rf_zero),
    .bits_i       (rf_bits_in),
    .scale_i      (cfg_i.gradient),
    .load_o       (rf_load),
    .mag_o        (rf_mag),
    .bits_o       (rf_bits)
  );

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      base_stp = start ? 9'sd0 : stp_b[c];
      if (rf_load) begin
        base_stp = $signed({1'b0, rf_mag[c]});
      end
      if (start) begin
        // three inversion bits follow the consumed increment group
        lvl_s[c] = rf_bits[c] ? 10'sd255 : 10'sd0;
        stp_s[c] = rf_bits[c] ? -base_stp : base_stp;
      end else begin
        lvl_s[c] = lvl_b[c];
        stp_s[c] = base_stp;
      end
      lvl_nxt[c] = lvl_s[c] + {stp_s[c][8], stp_s[c]};
      stp_nxt[c] = stp_s[c];
    end
    sbl_nxt = start ? (rf_bits >> 3) : rf_bits;
    bbl_nxt = start ? cfg_i.bounce_pattern : bbl_b;
  end

  assign fixed_rgb = FIXED_MAP[idx];

  always_comb begin
    pix_o.idx = idx;
    if (grad_on) begin
      pix_o.red   = lvl_s[0][7:0];
      pix_o.green = lvl_s[1][7:0];
      pix_o.blue  = lvl_s[2][7:0];
    end else begin
      pix_o.red   = fixed_rgb[23:16];
      pix_o.green = fixed_rgb[15:8];
      pix_o.blue  = fixed_rgb[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_idx_r <= '0;
      sbl_r      <= '0;
      bbl_r      <= '0;
      for (int c = 0; c < 3; c++) begin
        lvl_r[c] <= '0;
        stp_r[c] <= '0;
      end
    end else if (step_i) begin
      next_idx_r <= idx + 8'd1;
      if (grad_on) begin
        sbl_r <= sbl_nxt;
        bbl_r <= bbl_nxt;
        for (int c = 0; c < 3; c++) begin
          lvl_r[c] <= lvl_nxt[c];
          stp_r[c] <= stp_nxt[c];
        end
      end
    end
  end

  `BPG_ASSERT_NOW(a_lvl_range, clk, rst_n, 1'b1,
    lvl_r[0] <= 10'sd444 && lvl_r[0] >= -10'sd189 &&
    lvl_r[1] <= 10'sd444 && lvl_r[1] >= -10'sd189 &&
    lvl_r[2] <= 10'sd444 && lvl_r[2] >= -10'sd189)
  `BPG_ASSERT_NEXT(a_bits_shrink, clk, rst_n, step_i && !start,
    sbl_r <= $past(sbl_r) && bbl_r <= $past(bbl_r))

endmodule

// ----- tb/sv/bouncing_palette_generator_top_test.sv -----
// Self-checking testbench for the bouncing palette generator top level.
`timescale 1ns / 1ps

module bouncing_palette_generator_top_test;
  import bpg_pkg::*;

  // Spare register indexes: the block must ignore writes to them.
  localparam logic [2:0] CFG_SPARE_LO = 3'd4;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  // Cycles with no handshake on either channel before the run is declared hung.
  localparam int STALL_LIMIT = 1000;
  // Cycles to let pass after the last entry, well over the pipeline latency.
  localparam int TAIL_CYCLES = 8;
  localparam int NUM_PHASES = 10;

  typedef struct packed {
    logic [7:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } entry_t;

  typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_e;

  // One line of the directed script: either a register write or a request.
  // A request row with typed set carries its expected entry; the rest go
  // through the palette predictor.
  typedef struct packed {
    row_kind_e  kind;
    logic [2:0] reg_sel;
    pat_t       value;
    logic       restart;
    logic       typed;
    entry_t     want;
  } row_t;

  localparam entry_t NO_ENTRY = '0;
  localparam int NUM_ROWS = 34;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_entry_index;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic        out_last;

  // Shadow copy of the configuration registers.
  logic [5:0] grad_reg = '0;
  pat_t       start_reg = '0;
  pat_t       bounce_reg = '0;
  logic [7:0] alpha_reg = '0;

  // Palette state of the predictor, channels ordered red, green, blue.
  int         chan_level [3] = '{0, 0, 0};
  int         chan_step [3] = '{0, 0, 0};
  pat_t       start_left = '0;
  pat_t       bounce_left = '0;
  logic [7:0] next_idx = '0;

  entry_t pending_entries [$];
  entry_t head;
  int     errors = 0;
  int     stalled_cycles = 0;
  bit     steady = 1'b0;

  // Directed script. Covers: fixed map right after reset and on restart,
  // every register at its extremes, writes to spare indexes, palette start
  // with inverted channels, bounce off both rails, gradient dropped to zero
  // and raised again mid-palette with held levels, refill skipping a zero
  // group, an exhausted bounce pattern clamping every channel, and a
  // nonzero gradient with no start pattern at all.
  row_t script_rows [NUM_ROWS] = '{
    '{ROW_REQUEST, REG_GRADIENT, 31'd0, 1'b0, 1'b1, {8'd0, 8'd64, 8'd64, 8'd64, 8'd0, 1'b0}},
    '{ROW_REQUEST, REG_GRADIENT, 31'd0, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_REQUEST, REG_GRADIENT, 31'd0, 1'b1, 1'b1, {8'd0, 8'd64, 8'd64, 8'd64, 8'd0, 1'b0}},
    '{ROW_WRITE, REG_GRADIENT, 31'd63, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_WRITE, REG_START_PATTERN, 31'h7FFF_FFFF, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_WRITE, REG_BOUNCE_PATTERN, 31'h7FFF_FFFF, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_WRITE, REG_ALPHA_VALUE, 31'd255, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_WRITE, CFG_SPARE_LO, 31'd0, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_WRITE, CFG_SPARE_HI, 31'd0, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_REQUEST, REG_GRADIENT, 31'd0, 1'b1, 1'b1,
      {8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0}},
    '{ROW_REQUEST, REG_GRADIENT, 31'd0, 1'b0, 1'b1, {8'd1, 8'd66, 8'd66, 8'd66, 8'd255, 1'b0}},
    '{ROW_REQUEST, REG_GRADIENT, 31'd0, 1'b0, 1'b1, {8'd2, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0}},
    '{ROW_REQUEST, REG_GRADIENT, 31'd0, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_REQUEST, REG_GRADIENT, 31'd0, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_WRITE, REG_GRADIENT, 31'd0, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_REQUEST, REG_GRADIENT, 31'd0, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_WRITE, REG_GRADIENT, 31'd1, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_REQUEST, REG_GRADIENT, 31'd0, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_REQUEST, REG_GRADIENT, 31'd0, 1'b0, 1'b0, NO_ENTRY},
    // zero first group, then magnitudes 1, 2, 3 and green starting high
    '{ROW_WRITE, REG_START_PATTERN, 31'h0000_2E40, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_WRITE, REG_BOUNCE_PATTERN, 31'd0, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_WRITE, REG_GRADIENT, 31'd40, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_WRITE, REG_ALPHA_VALUE, 31'h5A, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_REQUEST, REG_GRADIENT, 31'd0, 1'b1, 1'b0, NO_ENTRY},
    '{ROW_REQUEST, REG_GRADIENT, 31'd0, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_REQUEST, REG_GRADIENT, 31'd0, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_REQUEST, REG_GRADIENT, 31'd0, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_REQUEST, REG_GRADIENT, 31'd0, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_REQUEST, REG_GRADIENT, 31'd0, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_REQUEST, REG_GRADIENT, 31'd0, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_REQUEST, REG_GRADIENT, 31'd0, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_WRITE, REG_START_PATTERN, 31'd0, 1'b0, 1'b0, NO_ENTRY},
    '{ROW_REQUEST, REG_GRADIENT, 31'd0, 1'b1, 1'b1, {8'd0, 8'd0, 8'd0, 8'd0, 8'h5A, 1'b0}},
    '{ROW_REQUEST, REG_GRADIENT, 31'd0, 1'b0, 1'b1, {8'd1, 8'd0, 8'd0, 8'd0, 8'h5A, 1'b0}}
  };

  bouncing_palette_generator_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_entry_index (out_entry_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Consume start groups while every channel is stalled and bits remain.
  function automatic void refill_steps(input int scale);
    int c;
    while (chan_step[0] == 0 && chan_step[1] == 0 && chan_step[2] == 0 && start_left != '0) begin
      for (c = 0; c < 3; c++) begin
        chan_step[c] = scale * int'(start_left[1:0]);
        start_left = start_left >> 2;
      end
    end
  endfunction

  // Advance the palette by one request and return the entry it produces.
  function automatic entry_t next_palette_entry(input logic restart);
    entry_t e;
    int     idx;
    int     scale;
    int     col [3];
    int     c;
    if (restart) next_idx = '0;
    idx = next_idx;
    scale = grad_reg;
    if (scale == 0) begin
      // Fixed four-segment map; the bouncing state is left alone.
      if (idx < 85) begin
        col[2] = (2 * 64 * (255 - 3 * idx) + 255) / 510;
        col[0] = col[2];
        col[1] = (2 * (64 * 255 + 384 * idx) + 255) / 510;
      end else if (idx < 170) begin
        col[2] = 0;
        col[1] = (2 * (129 * 255 + 189 * idx) + 255) / 510;
        col[0] = 3 * idx - 255;
      end else if (idx < 255) begin
        col[2] = 0;
        col[1] = 765 - 3 * idx;
        col[0] = 255;
      end else begin
        col[2] = 0;
        col[1] = 0;
        col[0] = 255;
      end
    end else begin
      if (idx == 0) begin
        // Reload the whole palette state from the live registers.
        for (c = 0; c < 3; c++) begin
          chan_level[c] = 0;
          chan_step[c] = 0;
        end
        start_left = start_reg;
        bounce_left = bounce_reg;
        refill_steps(scale);
        for (c = 0; c < 3; c++) begin
          if (start_left[0]) begin
            chan_level[c] = 255;
            chan_step[c] = -chan_step[c];
          end
          start_left = start_left >> 1;
        end
      end
      // Clamp at either rail and bounce with the next two-bit magnitude.
      for (c = 0; c < 3; c++) begin
        if (chan_level[c] > 255) begin
          chan_step[c] = -scale * int'(bounce_left[1:0]);
          bounce_left = bounce_left >> 2;
          chan_level[c] = 255;
        end
        if (chan_level[c] < 0) begin
          chan_step[c] = scale * int'(bounce_left[1:0]);
          bounce_left = bounce_left >> 2;
          chan_level[c] = 0;
        end
      end
      refill_steps(scale);
      for (c = 0; c < 3; c++) begin
        col[c] = chan_level[c] & 255;
        chan_level[c] = chan_level[c] + chan_step[c];
      end
    end
    e.index = 8'(idx);
    e.red = 8'(col[0]);
    e.green = 8'(col[1]);
    e.blue = 8'(col[2]);
    e.alpha = alpha_reg;
    e.last = (idx == 255);
    next_idx = 8'(idx + 1);
    return e;
  endfunction

  // Drive the write, wait for a clock edge and mirror it into the shadow copy.
  // Leave cfg_we high: the next request, write or idle burst sets it.
  task automatic write_cfg(input logic [2:0] sel, input pat_t value);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    case (sel)
      REG_GRADIENT:       grad_reg = value[5:0];
      REG_START_PATTERN:  start_reg = value;
      REG_BOUNCE_PATTERN: bounce_reg = value;
      REG_ALPHA_VALUE:    alpha_reg = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one request and hold it until accepted; valid stays high on return.
  task automatic push_request(input logic restart, input logic typed, input entry_t want);
    entry_t predicted;
    cfg_we <= 1'b0;
    in_valid <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = next_palette_entry(restart);
    pending_entries.push_back(typed ? want : predicted);
  endtask

  task automatic wait_for_drain();
    while (pending_entries.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Stimulus: reset, directed script, then random phases with fresh settings.
  initial begin
    int       ph;
    int       n;
    int       count;
    int       grad_val;
    pat_t     pat_val;
    logic     restart;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script_rows[k]) begin
      if (script_rows[k].kind == ROW_WRITE) begin
        // Drop valid and let the pipe empty before touching a register.
        in_valid <= 1'b0;
        wait_for_drain();
        write_cfg(script_rows[k].reg_sel, script_rows[k].value);
      end else begin
        push_request(script_rows[k].restart, script_rows[k].typed, script_rows[k].want);
      end
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      // Every phase boundary holds the sender until all entries are back.
      in_valid <= 1'b0;
      wait_for_drain();
      // The final phase runs flat out on both sides; some others do too.
      steady = (ph == NUM_PHASES - 1) || ($urandom_range(0, 4) == 0);
      if (ph == 0) begin
        // Walk the whole fixed map, through entry 255 and the wrap.
        write_cfg(REG_GRADIENT, '0);
        write_cfg(REG_ALPHA_VALUE, pat_t'($urandom_range(0, 255)));
        count = 300;
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 5))
            0:       grad_val = 0;
            1:       grad_val = 63;
            2:       grad_val = 1;
            default: grad_val = $urandom_range(1, 63);
          endcase
          write_cfg(REG_GRADIENT, pat_t'(grad_val));
        end
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 5))
            0:       pat_val = '0;
            1:       pat_val = 31'h7FFF_FFFF;
            2:       pat_val = pat_t'($urandom_range(0, 511));
            // push the live groups up behind zero groups
            3:       pat_val = pat_t'($urandom) << (6 * $urandom_range(1, 3));
            default: pat_val = pat_t'($urandom);
          endcase
          write_cfg(REG_START_PATTERN, pat_val);
        end
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 3))
            0:       pat_val = '0;
            1:       pat_val = 31'h7FFF_FFFF;
            default: pat_val = pat_t'($urandom);
          endcase
          write_cfg(REG_BOUNCE_PATTERN, pat_val);
        end
        if ($urandom_range(0, 3) != 0)
          write_cfg(REG_ALPHA_VALUE, pat_t'($urandom_range(0, 255)));
        count = $urandom_range(60, 125);
      end

      for (n = 0; n < count; n++) begin
        if (!steady && $urandom_range(0, 5) == 0) begin
          cfg_we <= 1'b0;
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        // Mostly let palettes run long; restart now and then.
        if (n == 0) restart = (ph == 0) || ($urandom_range(0, 1) == 0);
        else restart = ($urandom_range(0, 99) == 0);
        push_request(restart, 1'b0, NO_ENTRY);
      end
    end

    in_valid <= 1'b0;
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side back-pressure: random stall bursts unless the phase is steady.
  initial begin
    forever begin
      if (!steady && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // Compare every accepted entry with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_entries.size() == 0) begin
        $display("%0t: entry %0d arrived with no request waiting", $time, out_entry_index);
        errors++;
      end else begin
        head = pending_entries.pop_front();
        check_field("entry_index", head.index, out_entry_index);
        check_field("red", head.red, out_red);
        check_field("green", head.green, out_green);
        check_field("blue", head.blue, out_blue);
        check_field("alpha", head.alpha, out_alpha);
        check_field("last", head.last, out_last);
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles == STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
